@@ hdl/aes_round_unit_macros.svh @@
// ----------------------------------------------------------------------------
// aes_round_unit_macros
// Assertion macros for the AES round unit; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef AES_ROUND_UNIT_MACROS_SVH
`define AES_ROUND_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AESR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aes_round_unit: check failed");

// next-cycle implication
`define AESR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aes_round_unit: check failed");

`else

`define AESR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AESR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/aesr_pkg.sv @@
// ----------------------------------------------------------------------------
// aesr_pkg
// Operation codes, S-box tables and column mixing functions for the AES round.
// ----------------------------------------------------------------------------
package aesr_pkg;

  localparam int COL_W  = 32;
  localparam int NCOLS  = 4;
  localparam int FUNC_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_ENC      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENC_LAST = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEC      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEC_LAST = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_KEY      = 3'd4;

  typedef logic [NCOLS-1:0][COL_W-1:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [COL_W-1:0] mix_col(input logic [COL_W-1:0] w);
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] d0, d1, d2, d3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    d0 = xtime(a0);
    d1 = xtime(a1);
    d2 = xtime(a2);
    d3 = xtime(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            d1 ^ d2 ^ a2 ^ a3 ^ a0,
            d2 ^ d3 ^ a3 ^ a0 ^ a1,
            d3 ^ d0 ^ a0 ^ a1 ^ a2};
  endfunction

  function automatic logic [COL_W-1:0] inv_mix_col(input logic [COL_W-1:0] w);
    logic [3:0][7:0] a, m2, m4, m8, m9, m11, m13, m14;
    for (int i = 0; i < 4; i++) begin
      a[i]   = w[8*(3-i) +: 8];
      m2[i]  = xtime(a[i]);
      m4[i]  = xtime(m2[i]);
      m8[i]  = xtime(m4[i]);
      m9[i]  = m8[i] ^ a[i];
      m11[i] = m8[i] ^ m2[i] ^ a[i];
      m13[i] = m8[i] ^ m4[i] ^ a[i];
      m14[i] = m8[i] ^ m4[i] ^ m2[i];
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m14[1] ^ m11[2] ^ m13[3] ^ m9[0],
            m14[2] ^ m11[3] ^ m13[0] ^ m9[1],
            m14[3] ^ m11[0] ^ m13[1] ^ m9[2]};
  endfunction

endpackage

@@ hdl/aes_round_unit.sv @@
// ----------------------------------------------------------------------------
// aes_round_unit
// One AES-128 round (encrypt, encrypt last, decrypt, decrypt last, add key).
//
//   channel   dir  handshake                       payload
//   s_axis    in   s_axis_tvalid / s_axis_tready   tdata: state, key; tuser: func
//   m_axis    out  m_axis_tvalid / m_axis_tready   tdata: result columns
//
// Three register stages: shift rows and S-box, mix columns and key add,
// inverse mix columns. One word per cycle enters unless the output stalls.
// Each stage loads when empty or when the stage after it moves, so bubbles
// collapse and a stalled output holds without loss.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`include "aes_round_unit_macros.svh"

module aes_round_unit
  import aesr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // state_col0..3 [127:0], key_col0..3 [255:128]
  input  logic [255:0] s_axis_tdata,
  // func [2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_col0..3 [127:0]
  output logic [127:0] m_axis_tdata
);

  logic        v1, v2, v3;
  logic        ready1, ready2, ready3;
  logic [FUNC_W-1:0] fn1, fn2;
  block_t      st1, st2, st3;
  block_t      key1;
  block_t      st1_next, st2_next, st3_next;
  block_t      in_state, in_key;

  assign ready3 = !v3 || m_axis_tready;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign s_axis_tready = ready1;

  always_comb begin
    for (int c = 0; c < NCOLS; c++) begin
      in_state[c] = s_axis_tdata[COL_W*c +: COL_W];
      in_key[c]   = s_axis_tdata[COL_W*(NCOLS+c) +: COL_W];
    end
  end

  // shift rows and byte substitution
  always_comb begin
    logic [1:0] fc, rc;
    logic [7:0] src;
    for (int c = 0; c < NCOLS; c++) begin
      for (int r = 0; r < 4; r++) begin
        fc = 2'(c + r);
        rc = 2'(c + 4 - r);
        case (s_axis_tuser)
          FUNC_ENC, FUNC_ENC_LAST: begin
            src = in_state[fc][8*(3-r) +: 8];
            st1_next[c][8*(3-r) +: 8] = SBOX[src];
          end
          FUNC_DEC, FUNC_DEC_LAST: begin
            src = in_state[rc][8*(3-r) +: 8];
            st1_next[c][8*(3-r) +: 8] = INV_SBOX[src];
          end
          default: begin
            src = in_state[c][8*(3-r) +: 8];
            st1_next[c][8*(3-r) +: 8] = src;
          end
        endcase
      end
    end
  end

  // mix columns and key add
  always_comb begin
    for (int c = 0; c < NCOLS; c++) begin
      if (fn1 == FUNC_ENC) begin
        st2_next[c] = mix_col(st1[c]) ^ key1[c];
      end else if (fn1 inside {FUNC_ENC_LAST, FUNC_DEC, FUNC_DEC_LAST, FUNC_KEY}) begin
        st2_next[c] = st1[c] ^ key1[c];
      end else begin
        st2_next[c] = st1[c];
      end
    end
  end

  // inverse mix columns
  always_comb begin
    for (int c = 0; c < NCOLS; c++) begin
      st3_next[c] = (fn2 == FUNC_DEC) ? inv_mix_col(st2[c]) : st2[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= s_axis_tvalid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      st1  <= st1_next;
      key1 <= in_key;
      fn1  <= s_axis_tuser;
    end
    if (ready2) begin
      st2 <= st2_next;
      fn2 <= fn1;
    end
    if (ready3) begin
      st3 <= st3_next;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = st3;

  `AESR_ASSERT_NEXT(a_accept_fills, clk, rst, s_axis_tvalid && s_axis_tready, v1)
  `AESR_ASSERT_NEXT(a_advance_s2, clk, rst, v1 && ready2, v2)
  `AESR_ASSERT_NEXT(a_hold_s2, clk, rst, v2 && !ready3, v2 && $stable(st2) && $stable(fn2))

endmodule

@@ dv/aes_round_unit_tb.sv @@
// ----------------------------------------------------------------------------
// aes_round_unit_tb
// Self-checking bench for the AES round unit. A directed table covers each
// operation, the unused codes and all-zero/all-one blocks. Random blocks then
// follow, with stalls on both sides. Each result is compared column by column
// with the row's known result or a behavioural GF(2^8) round in this file.
// ----------------------------------------------------------------------------
module aes_round_unit_tb
  import aesr_pkg::*;
();

  typedef logic [NCOLS-1:0][COL_W-1:0] cols_t;
  typedef logic [3:0][3:0][7:0] grid_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    cols_t             st;
    cols_t             key;
    bit                known;
    cols_t             res;
  } vec_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    cols_t             res;
  } round_result_t;

  localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

  localparam cols_t ALL_ZERO = '0;
  localparam cols_t ALL_ONES = '1;

  localparam int N_BLOCKS    = 500;
  localparam int STEADY_TAIL = 60;
  localparam int PAUSE_AT    = 300;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  logic [7:0] sbox_fwd [256];
  logic [7:0] sbox_inv [256];

  round_result_t pending_rounds[$];

  bit    steady;
  bit    drive_known;
  cols_t drive_res;
  int    blocks_in;
  int    blocks_out;
  int    mismatches;
  int    quiet_cycles;
  int    func_seen [8];

  aes_round_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // a^254 is the field inverse, and zero maps to zero
  function automatic logic [7:0] gf_recip(logic [7:0] a);
    logic [7:0] acc;
    logic [7:0] base;
    acc  = 8'h01;
    base = a;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) acc = gf_mul(acc, base);
      base = gf_mul(base, base);
    end
    return acc;
  endfunction

  function automatic grid_t mix_grid(grid_t g, bit inverse);
    grid_t      m;
    logic [7:0] k0, k1, k2, k3;
    k0 = inverse ? 8'd14 : 8'd2;
    k1 = inverse ? 8'd11 : 8'd3;
    k2 = inverse ? 8'd13 : 8'd1;
    k3 = inverse ? 8'd9  : 8'd1;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        m[r][c] = gf_mul(g[r][c], k0) ^ gf_mul(g[(r + 1) % 4][c], k1)
                ^ gf_mul(g[(r + 2) % 4][c], k2) ^ gf_mul(g[(r + 3) % 4][c], k3);
    return m;
  endfunction

  function automatic cols_t predict_round(logic [FUNC_W-1:0] fn, cols_t st, cols_t key);
    grid_t g;
    grid_t t;
    cols_t res;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        g[r][c] = st[c][8*(3-r) +: 8];
    if (fn == FUNC_ENC || fn == FUNC_ENC_LAST) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[r][c] = sbox_fwd[g[r][(c + r) % 4]];
      g = t;
    end else if (fn == FUNC_DEC || fn == FUNC_DEC_LAST) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[r][c] = sbox_inv[g[r][(c + 4 - r) % 4]];
      g = t;
    end
    if (fn == FUNC_ENC) g = mix_grid(g, 1'b0);
    if (fn <= FUNC_KEY)
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          g[r][c] ^= key[c][8*(3-r) +: 8];
    if (fn == FUNC_DEC) g = mix_grid(g, 1'b1);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        res[c][8*(3-r) +: 8] = g[r][c];
    return res;
  endfunction

  function automatic cols_t rand_cols();
    cols_t v;
    for (int c = 0; c < 4; c++)
      case ($urandom_range(0, 9))
        0:       v[c] = 32'h0000_0000;
        1:       v[c] = 32'hffff_ffff;
        default: v[c] = $urandom;
      endcase
    return v;
  endfunction

  task automatic offer_block(vec_t v);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v.key, v.st};
    s_axis_tuser  <= v.fn;
    drive_known   <= v.known;
    drive_res     <= v.res;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // scoreboard and watchdog
  always @(posedge clk) begin
    round_result_t want;
    cols_t         got;
    logic [FUNC_W-1:0] fn_in;
    cols_t         st_in, key_in;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        fn_in  = s_axis_tuser;
        st_in  = s_axis_tdata[127:0];
        key_in = s_axis_tdata[255:128];
        want.fn  = fn_in;
        want.res = drive_known ? drive_res : predict_round(fn_in, st_in, key_in);
        pending_rounds.push_back(want);
        func_seen[fn_in]++;
        blocks_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        blocks_out++;
        got = m_axis_tdata;
        if (pending_rounds.size() == 0) begin
          $error("unexpected result word %032h", got);
          mismatches++;
        end else begin
          want = pending_rounds.pop_front();
          for (int c = 0; c < 4; c++)
            if (got[c] !== want.res[c]) begin
              $error("out_col%0d (func %0d): expected %08h, actual %08h",
                     c, want.fn, want.res[c], got[c]);
              mismatches++;
            end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, one long hold while blocks keep coming, then always ready
  initial begin
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (steady) begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end else if (!held && blocks_in >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  initial begin
    vec_t rows[$];
    vec_t v;
    logic [7:0] b;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_ENC;
    drive_known   = 1'b0;
    drive_res     = '0;
    steady        = 1'b0;

    for (int x = 0; x < 256; x++) begin
      b = gf_recip(8'(x));
      sbox_fwd[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                  ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) sbox_inv[sbox_fwd[x]] = 8'(x);

    rows.push_back(vec_t'{FUNC_KEY, ALL_ZERO, ALL_ZERO, 1'b1, ALL_ZERO});
    rows.push_back(vec_t'{FUNC_KEY, ALL_ONES, ALL_ZERO, 1'b1, ALL_ONES});
    rows.push_back(vec_t'{FUNC_KEY, ALL_ZERO, ALL_ONES, 1'b1, ALL_ONES});
    rows.push_back(vec_t'{FUNC_KEY, ALL_ONES, ALL_ONES, 1'b1, ALL_ZERO});
    rows.push_back(vec_t'{FUNC_ENC, ALL_ZERO, ALL_ZERO, 1'b1, {4{32'h63636363}}});
    rows.push_back(vec_t'{FUNC_ENC_LAST, ALL_ZERO, ALL_ZERO, 1'b1, {4{32'h63636363}}});
    rows.push_back(vec_t'{FUNC_ENC_LAST, ALL_ONES, ALL_ZERO, 1'b1, {4{32'h16161616}}});
    rows.push_back(vec_t'{FUNC_DEC, ALL_ZERO, ALL_ZERO, 1'b1, {4{32'h52525252}}});
    rows.push_back(vec_t'{FUNC_DEC_LAST, ALL_ZERO, ALL_ZERO, 1'b1, {4{32'h52525252}}});
    rows.push_back(vec_t'{FUNC_DEC_LAST, ALL_ONES, ALL_ZERO, 1'b1, {4{32'h7d7d7d7d}}});
    // unused codes pass the state through untouched
    rows.push_back(vec_t'{FUNC_RSVD5, {4{32'ha5a5a5a5}}, ALL_ONES, 1'b1,
                          {4{32'ha5a5a5a5}}});
    rows.push_back(vec_t'{FUNC_RSVD6, ALL_ONES, {4{32'h5a5a5a5a}}, 1'b1, ALL_ONES});
    rows.push_back(vec_t'{FUNC_RSVD7, {4{32'h5a5a5a5a}}, ALL_ONES, 1'b1,
                          {4{32'h5a5a5a5a}}});
    rows.push_back(vec_t'{FUNC_KEY,
                          {32'he0370734, 32'h313198a2, 32'h885a308d, 32'h3243f6a8},
                          {32'h09cf4f3c, 32'habf71588, 32'h28aed2a6, 32'h2b7e1516},
                          1'b0, ALL_ZERO});
    rows.push_back(vec_t'{FUNC_ENC,
                          {32'he9f84808, 32'h9ac68d2a, 32'ha0f4e22b, 32'h193de3be},
                          {32'h2a6c7605, 32'h23a33905, 32'h88542cb1, 32'ha0fafe17},
                          1'b0, ALL_ZERO});
    rows.push_back(vec_t'{FUNC_DEC,
                          {32'h026a5049, 32'h6b5bea43, 32'h689f352b, 32'ha49c7ff2},
                          {32'h2a6c7605, 32'h23a33905, 32'h88542cb1, 32'ha0fafe17},
                          1'b0, ALL_ZERO});
    rows.push_back(vec_t'{FUNC_ENC, ALL_ONES, ALL_ONES, 1'b0, ALL_ZERO});
    rows.push_back(vec_t'{FUNC_DEC, ALL_ONES, ALL_ONES, 1'b0, ALL_ZERO});
    rows.push_back(vec_t'{FUNC_ENC_LAST, {4{32'h00ff00ff}}, {4{32'hff00ff00}}, 1'b0,
                          ALL_ZERO});
    rows.push_back(vec_t'{FUNC_DEC_LAST, {4{32'h0f1e2d3c}}, {4{32'h80402010}}, 1'b0,
                          ALL_ZERO});

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      if ($urandom_range(0, 2) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      offer_block(rows[i]);
    end

    for (int n = rows.size(); n < N_BLOCKS; n++) begin
      if (n == N_BLOCKS - STEADY_TAIL) steady = 1'b1;
      if (n == PAUSE_AT) begin
        s_axis_tvalid <= 1'b0;
        while (pending_rounds.size() != 0) @(negedge clk);
        @(negedge clk);
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      v.fn    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
      v.st    = rand_cols();
      v.key   = rand_cols();
      v.known = 1'b0;
      v.res   = ALL_ZERO;
      offer_block(v);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_rounds.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Covered %0d blocks in, %0d out: enc %0d, enc last %0d, dec %0d,",
             blocks_in, blocks_out, func_seen[FUNC_ENC], func_seen[FUNC_ENC_LAST],
             func_seen[FUNC_DEC]);
    $display("  dec last %0d, add key %0d, unused codes %0d; %0d mismatches",
             func_seen[FUNC_DEC_LAST], func_seen[FUNC_KEY],
             func_seen[FUNC_RSVD5] + func_seen[FUNC_RSVD6] + func_seen[FUNC_RSVD7],
             mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
